@@ hdl/record_cache_lru_directory_macros.svh @@
// Assertion macros used by the record cache directory checker.
`ifndef RECORD_CACHE_LRU_DIRECTORY_MACROS_SVH
`define RECORD_CACHE_LRU_DIRECTORY_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define RCLD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("record cache directory check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define RCLD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("record cache directory check failed");

`endif

@@ hdl/rcld_pkg.sv @@
// Package with the shared types and constants of the record cache directory.
package rcld_pkg;

  localparam logic [1:0] ACT_GET     = 2'd0;
  localparam logic [1:0] ACT_FRESH   = 2'd1;
  localparam logic [1:0] ACT_RELEASE = 2'd2;

  localparam logic [5:0] CAPACITY_RESET = 6'd20;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_GRANT,
    S_POP,
    S_POP_CAP,
    S_EV_RD,
    S_SHIFT,
    S_APPEND,
    S_PUSH,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    PH_LOOKUP,
    PH_KEEP,
    PH_RELEASE
  } phase_t;

endpackage

@@ hdl/rcld_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module rcld_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/record_cache_lru_directory.sv @@
// Top level of the record cache directory: LRU list, free stack and sequencer.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------------------------
//  request | start in, busy out   | action, record_number, keep_in_cache, record_on_disk
//  result  | done out (strobe)    | hit, granted_record, took_*_record, evict_*, free_overflow
//  config  | cfg_valid, cfg_ready | cfg_data, the cache capacity
//
// A request beat is taken when start is high and busy is low. The time a request keeps the
// block busy grows with the number of cached records, since a hit, and a kept miss that
// pops the free stack and evicts, both walk the list, and the one read port of the
// recency list RAM is scanned and compacted one entry per cycle. Synchronous reset clears
// the fill counts and the new-number counter and loads a capacity of 20. The result beat
// shows for one cycle with done high, cannot be stalled, and busy drops the cycle after.
module record_cache_lru_directory
  import rcld_pkg::*;
#(
  parameter int CACHE_DEPTH = 32,
  parameter int FREE_DEPTH  = 256,
  parameter int RECORD_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  // Request channel.
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             action,
  input  logic [RECORD_BITS-1:0] record_number,
  input  logic                   keep_in_cache,
  input  logic                   record_on_disk,
  // Result channel.
  output logic                   done,
  output logic                   hit,
  output logic [RECORD_BITS-1:0] granted_record,
  output logic                   took_free_record,
  output logic                   took_new_record,
  output logic                   evict_valid,
  output logic [RECORD_BITS-1:0] evict_record,
  output logic                   free_overflow,
  // Configuration channel.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [5:0]             cfg_data
);

  // Widths of list indexes and counts, and of free stack addresses and counts.
  localparam int LAW  = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
  localparam int CW   = $clog2(CACHE_DEPTH + 1);
  localparam int FAW  = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
  localparam int FCW  = $clog2(FREE_DEPTH + 1);
  localparam int CMPW = (CW > 6) ? CW : 6;

  state_t state, state_next;
  phase_t phase;

  // Capacity register and its clamped form.
  logic [5:0]      capacity;
  logic [CMPW-1:0] cap_ext;
  logic [CMPW-1:0] cap_eff;
  logic [CMPW-1:0] count_ext;
  logic            list_full;

  // Directory state.
  logic [CW-1:0]          count;
  logic [FCW-1:0]         free_count;
  logic [RECORD_BITS-1:0] next_new;

  // Latched request and working registers.
  logic [1:0]             act;
  logic                   keep;
  logic                   on_disk;
  logic [RECORD_BITS-1:0] target;
  logic [CW-1:0]          ptr;
  logic                   cmp_vld;
  logic                   pend;
  logic                   ev_cap;

  // RAM ports.
  logic                   list_we;
  logic [LAW-1:0]         list_waddr;
  logic [RECORD_BITS-1:0] list_wdata;
  logic [LAW-1:0]         list_raddr;
  logic [RECORD_BITS-1:0] list_rdata;
  logic                   free_we;
  logic [FAW-1:0]         free_waddr;
  logic [FAW-1:0]         free_raddr;
  logic [RECORD_BITS-1:0] free_rdata;

  logic match;
  logic scan_more;
  logic take_disk;

  assign cfg_ready = 1'b1;
  assign busy      = (state != S_IDLE);
  assign done      = (state == S_DONE);

  // A capacity of zero behaves as one, and anything above the list depth as the depth.
  assign cap_ext   = CMPW'(capacity);
  assign count_ext = CMPW'(count);
  always_comb begin
    if (cap_ext == '0) begin
      cap_eff = CMPW'(1);
    end else if (cap_ext > CMPW'(CACHE_DEPTH)) begin
      cap_eff = CMPW'(CACHE_DEPTH);
    end else begin
      cap_eff = cap_ext;
    end
  end
  assign list_full = (count_ext >= cap_eff);

  // The list RAM returns entry ptr-1 while cmp_vld is set during a search.
  assign match     = cmp_vld && (list_rdata == target);
  assign scan_more = (ptr < count);
  assign take_disk = (act == ACT_GET) && on_disk;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          case (action)
            ACT_GET:     state_next = S_SEARCH;
            ACT_FRESH:   state_next = S_GRANT;
            ACT_RELEASE: state_next = S_SEARCH;
            default:     state_next = S_DONE;
          endcase
        end
      end
      S_SEARCH: begin
        if (match) begin
          state_next = S_SHIFT;
        end else if (!scan_more) begin
          case (phase)
            PH_LOOKUP:  state_next = S_GRANT;
            PH_KEEP:    state_next = list_full ? S_EV_RD : S_APPEND;
            PH_RELEASE: state_next = S_PUSH;
            default:    state_next = S_DONE;
          endcase
        end
      end
      S_GRANT: begin
        if (!take_disk && (free_count != '0)) begin
          state_next = S_POP;
        end else begin
          state_next = keep ? S_SEARCH : S_DONE;
        end
      end
      S_POP:     state_next = S_POP_CAP;
      S_POP_CAP: state_next = keep ? S_SEARCH : S_DONE;
      S_EV_RD:   state_next = S_SHIFT;
      S_SHIFT: begin
        if (!scan_more) begin
          state_next = (phase == PH_RELEASE) ? S_PUSH : S_APPEND;
        end
      end
      S_APPEND:  state_next = S_DONE;
      S_PUSH:    state_next = S_DONE;
      S_DONE:    state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // RAM controls for each state.
  always_comb begin
    list_we    = 1'b0;
    list_waddr = LAW'(count);
    list_wdata = target;
    list_raddr = LAW'(ptr);
    free_we    = 1'b0;
    free_waddr = FAW'(free_count);
    free_raddr = FAW'(free_count - FCW'(1));
    case (state)
      S_EV_RD: begin
        list_raddr = '0;
      end
      S_SHIFT: begin
        // Entry ptr-1 arrives now and moves down one place.
        list_we    = pend;
        list_waddr = LAW'(ptr - CW'(2));
        list_wdata = list_rdata;
      end
      S_APPEND: begin
        list_we = (count != CW'(CACHE_DEPTH));
      end
      S_PUSH: begin
        free_we = (free_count != FCW'(FREE_DEPTH));
      end
      default: begin
        list_we = 1'b0;
      end
    endcase
  end

  // Datapath and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      count      <= '0;
      free_count <= '0;
      next_new   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            act              <= action;
            keep             <= keep_in_cache;
            on_disk          <= record_on_disk;
            target           <= record_number;
            ptr              <= '0;
            cmp_vld          <= 1'b0;
            ev_cap           <= 1'b0;
            hit              <= 1'b0;
            granted_record   <= (action == ACT_RELEASE) ? record_number : '0;
            took_free_record <= 1'b0;
            took_new_record  <= 1'b0;
            evict_valid      <= 1'b0;
            evict_record     <= '0;
            free_overflow    <= 1'b0;
            phase            <= (action == ACT_RELEASE) ? PH_RELEASE : PH_LOOKUP;
          end
        end
        S_SEARCH: begin
          if (match) begin
            // The hit sits at ptr-1, so compaction starts reading at ptr.
            pend <= 1'b0;
            case (phase)
              PH_LOOKUP: begin
                hit            <= 1'b1;
                granted_record <= target;
              end
              PH_RELEASE: begin
                evict_valid  <= 1'b1;
                evict_record <= target;
              end
              default: begin
                hit <= 1'b0;
              end
            endcase
          end else if (scan_more) begin
            ptr     <= ptr + CW'(1);
            cmp_vld <= 1'b1;
          end
        end
        S_GRANT: begin
          if (take_disk) begin
            granted_record <= target;
          end else if (free_count != '0) begin
            free_count <= free_count;
          end else begin
            granted_record  <= next_new;
            target          <= next_new;
            took_new_record <= 1'b1;
            next_new        <= next_new + RECORD_BITS'(1);
          end
          phase   <= PH_KEEP;
          ptr     <= '0;
          cmp_vld <= 1'b0;
        end
        S_POP: begin
          free_count <= free_count - FCW'(1);
        end
        S_POP_CAP: begin
          granted_record   <= free_rdata;
          target           <= free_rdata;
          took_free_record <= 1'b1;
          ptr              <= '0;
          cmp_vld          <= 1'b0;
        end
        S_EV_RD: begin
          evict_valid <= 1'b1;
          ev_cap      <= 1'b1;
          ptr         <= CW'(1);
          pend        <= 1'b0;
        end
        S_SHIFT: begin
          if (ev_cap) begin
            evict_record <= list_rdata;
            ev_cap       <= 1'b0;
          end
          if (scan_more) begin
            ptr  <= ptr + CW'(1);
            pend <= 1'b1;
          end else begin
            pend  <= 1'b0;
            count <= count - CW'(1);
          end
        end
        S_APPEND: begin
          if (count != CW'(CACHE_DEPTH)) begin
            count <= count + CW'(1);
          end
        end
        S_PUSH: begin
          if (free_count != FCW'(FREE_DEPTH)) begin
            free_count <= free_count + FCW'(1);
          end else begin
            free_overflow <= 1'b1;
          end
        end
        default: begin
          ev_cap <= 1'b0;
        end
      endcase
    end
  end

  // In the disk-hit branch the target already holds the record; the grant state
  // loads the counter value into the target only when the counter is used.

  rcld_ram #(
    .WIDTH (RECORD_BITS),
    .DEPTH (CACHE_DEPTH)
  ) u_list_ram (
    .clk   (clk),
    .we    (list_we),
    .waddr (list_waddr),
    .wdata (list_wdata),
    .raddr (list_raddr),
    .rdata (list_rdata)
  );

  rcld_ram #(
    .WIDTH (RECORD_BITS),
    .DEPTH (FREE_DEPTH)
  ) u_free_ram (
    .clk   (clk),
    .we    (free_we),
    .waddr (free_waddr),
    .wdata (target),
    .raddr (free_raddr),
    .rdata (free_rdata)
  );

endmodule

@@ hdl/rcld_checker.sv @@
// Port-level checker for the record cache directory and its bind statement.
`include "record_cache_lru_directory_macros.svh"

module rcld_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic hit,
  input logic took_free_record,
  input logic took_new_record,
  input logic free_overflow
);

  // A result beat only appears while a request is being worked on.
  `RCLD_ASSERT_NOW(a_done_while_busy, done, busy)
  // An accepted request keeps the block busy in the following cycle.
  `RCLD_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // The block is free again right after delivering its result.
  `RCLD_ASSERT_NEXT(a_idle_after_done, done, !busy)
  // A hit never hands out a fresh record, a fresh record has one source, and a free stack overflow comes with neither.
  `RCLD_ASSERT_NOW(a_grant_source, done,
                   !(hit && (took_free_record || took_new_record)) &&
                   !(took_free_record && took_new_record) &&
                   !(free_overflow && (hit || took_free_record || took_new_record)))

endmodule

bind record_cache_lru_directory rcld_checker u_rcld_checker (.*);
